// ----- hdl/crf_pkg.sv -----
// crf_pkg: shared types and constants of the clipped rectangle fill engine
// used by crf_front, crf_queue, crf_back and the top level clipped_rectangle_fill
package crf_pkg;

  // command codes on the input channel
  localparam logic [1:0] CMD_FILL  = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BASE   = 2'd2;

  // field widths fixed by the register and channel formats
  localparam int CRD_W   = 9;
  localparam int COORD_W = 16;
  localparam int CLR_W   = 4;
  localparam int CNT_W   = 17;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // queue between the front and the back
  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = $clog2(Q_DEPTH);

  // what the back has to do for one command
  typedef enum logic [1:0] {
    OP_NONE,
    OP_PAINT,
    OP_READ
  } op_t;

  // one classified command: clipped span, or read position
  typedef struct packed {
    op_t              op;
    logic [CRD_W-1:0] x0;
    logic [CRD_W-1:0] x1;
    logic [CRD_W-1:0] y0;
    logic [CRD_W-1:0] y1;
    logic [CLR_W-1:0] color;
  } crf_entry_t;

  // back sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN,
    ST_READ,
    ST_DONE
  } bk_state_t;

endpackage

// ----- hdl/crf_if.sv -----
// crf_if: command and result channel interfaces of the fill engine
// no dependencies; payload widths follow the channel formats
interface crf_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic signed [15:0] x_left;
  logic signed [15:0] y_top;
  logic signed [15:0] x_right;
  logic signed [15:0] y_bottom;
  logic [3:0]         fill_color;

  modport source (output valid, cmd, x_left, y_top, x_right, y_bottom, fill_color,
                  input ready);
  modport sink (input valid, cmd, x_left, y_top, x_right, y_bottom, fill_color,
                output ready);
endinterface

interface crf_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  read_color;
  logic [16:0] pixels_written;

  modport source (output valid, read_color, pixels_written, input ready);
  modport sink (input valid, read_color, pixels_written, output ready);
endinterface

// ----- hdl/crf_front.sv -----
// crf_front: accepts commands, clips rectangles and classifies each word
// depends on crf_pkg and crf_in_if
module crf_front
  import crf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  crf_in_if.sink           in_ch,
  input  logic [CRD_W-1:0] eff_w,
  input  logic [CRD_W-1:0] eff_h,
  input  logic [CLR_W-1:0] clear_color,
  output logic             push_valid,
  input  logic             push_ready,
  output crf_entry_t       push_entry
);

  logic                      cls_v_r, cls_v_nxt;
  crf_entry_t                cls_r, cls_nxt;
  logic                      accept;
  logic signed [COORD_W:0]   xl, yt, xr, yb, ws, hs;
  logic signed [COORD_W:0]   cx0, cy0, cx1, cy1;

  // stage slot frees when its word moves into the queue
  assign in_ch.ready = !cls_v_r || push_ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // clip and classify
  always_comb begin
    xl  = {in_ch.x_left[COORD_W-1], in_ch.x_left};
    yt  = {in_ch.y_top[COORD_W-1], in_ch.y_top};
    xr  = {in_ch.x_right[COORD_W-1], in_ch.x_right};
    yb  = {in_ch.y_bottom[COORD_W-1], in_ch.y_bottom};
    ws  = {{(COORD_W+1-CRD_W){1'b0}}, eff_w};
    hs  = {{(COORD_W+1-CRD_W){1'b0}}, eff_h};
    cx0 = (xl < 0) ? '0 : xl;
    cy0 = (yt < 0) ? '0 : yt;
    cx1 = (xr > ws) ? ws : xr;
    cy1 = (yb > hs) ? hs : yb;

    cls_nxt.op    = OP_NONE;
    cls_nxt.x0    = '0;
    cls_nxt.x1    = '0;
    cls_nxt.y0    = '0;
    cls_nxt.y1    = '0;
    cls_nxt.color = in_ch.fill_color;
    case (in_ch.cmd)
      CMD_FILL: begin
        if (cx0 < cx1 && cy0 < cy1) begin
          cls_nxt.op = OP_PAINT;
          cls_nxt.x0 = cx0[CRD_W-1:0];
          cls_nxt.x1 = cx1[CRD_W-1:0];
          cls_nxt.y0 = cy0[CRD_W-1:0];
          cls_nxt.y1 = cy1[CRD_W-1:0];
        end
      end
      CMD_CLEAR: begin
        cls_nxt.color = clear_color;
        if (eff_w != '0 && eff_h != '0) begin
          cls_nxt.op = OP_PAINT;
          cls_nxt.x1 = eff_w;
          cls_nxt.y1 = eff_h;
        end
      end
      CMD_READ: begin
        if (xl >= 0 && xl < ws && yt >= 0 && yt < hs) begin
          cls_nxt.op = OP_READ;
          cls_nxt.x0 = xl[CRD_W-1:0];
          cls_nxt.y0 = yt[CRD_W-1:0];
        end
      end
      default: cls_nxt.op = OP_NONE;
    endcase
  end

  // stage valid
  always_comb begin
    cls_v_nxt = cls_v_r;
    if (accept) begin
      cls_v_nxt = 1'b1;
    end else if (push_ready) begin
      cls_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cls_v_r <= 1'b0;
    end else begin
      cls_v_r <= cls_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cls_r <= cls_nxt;
    end
  end

  assign push_valid = cls_v_r;
  assign push_entry = cls_r;

endmodule

// ----- hdl/crf_queue.sv -----
// crf_queue: short queue of classified commands between front and back
// depends on crf_pkg
module crf_queue
  import crf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_valid,
  output logic       wr_ready,
  input  crf_entry_t wr_entry,
  output logic       rd_valid,
  input  logic       rd_ready,
  output crf_entry_t rd_entry
);

  crf_entry_t          slot_r [Q_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]     count_r, count_nxt;
  logic                do_wr, do_rd;

  assign wr_ready = (count_r != (QPTR_W+1)'(Q_DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_entry = slot_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  // pointer and fill level update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(Q_DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(Q_DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_entry;
    end
  end

endmodule

// ----- hdl/crf_back.sv -----
// crf_back: pixel sequencer, frame store and result register
// depends on crf_pkg and crf_out_if
module crf_back
  import crf_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int COLOR_BITS = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  output logic             q_ready,
  input  crf_entry_t       q_entry,
  input  logic [CRD_W-1:0] eff_w,
  crf_out_if.source        out_ch
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);

  bk_state_t                 state_r, state_nxt;
  crf_entry_t                ent_r, ent_nxt;
  logic [ADDR_W-1:0]         row_base_r, row_base_nxt;
  logic [CRD_W-1:0]          x_r, x_nxt, y_r, y_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      out_v_r, out_v_nxt;
  logic [CLR_W-1:0]          out_color_r, out_color_nxt;
  logic [CNT_W-1:0]          out_cnt_r, out_cnt_nxt;
  logic [COLOR_BITS-1:0]     rdata_r;
  logic [COLOR_BITS-1:0]     frame [DEPTH];
  logic [ADDR_W-1:0]         addr;
  logic [2*CRD_W-1:0]        prod;
  logic                      last_x, last_y, wr_en, rd_en;
  logic [COLOR_BITS+CLR_W-1:0] wext, rext;
  logic [COLOR_BITS-1:0]     wdata;

  assign addr   = row_base_r + ADDR_W'(x_r);
  assign prod   = ent_r.y0 * eff_w;
  assign last_x = ({1'b0, x_r} + 1'b1) == {1'b0, ent_r.x1};
  assign last_y = ({1'b0, y_r} + 1'b1) == {1'b0, ent_r.y1};
  assign wext   = {{COLOR_BITS{1'b0}}, ent_r.color};
  assign wdata  = wext[COLOR_BITS-1:0];
  assign rext   = {{CLR_W{1'b0}}, rdata_r};
  assign wr_en  = (state_r == ST_RUN);
  assign rd_en  = (state_r == ST_READ);
  assign q_ready = (state_r == ST_IDLE);

  // sequencer: next state and datapath
  always_comb begin
    state_nxt     = state_r;
    ent_nxt       = ent_r;
    row_base_nxt  = row_base_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    cnt_nxt       = cnt_r;
    out_v_nxt     = out_v_r;
    out_color_nxt = out_color_r;
    out_cnt_nxt   = out_cnt_r;
    if (out_v_r && out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          ent_nxt   = q_entry;
          cnt_nxt   = '0;
          state_nxt = (q_entry.op == OP_NONE) ? ST_DONE : ST_SETUP;
        end
      end
      ST_SETUP: begin
        row_base_nxt = ADDR_W'(prod);
        x_nxt        = ent_r.x0;
        y_nxt        = ent_r.y0;
        state_nxt    = (ent_r.op == OP_READ) ? ST_READ : ST_RUN;
      end
      ST_RUN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (last_x) begin
          x_nxt        = ent_r.x0;
          y_nxt        = y_r + 1'b1;
          row_base_nxt = row_base_r + ADDR_W'(eff_w);
          if (last_y) begin
            state_nxt = ST_DONE;
          end
        end else begin
          x_nxt = x_r + 1'b1;
        end
      end
      ST_READ: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_v_r || out_ch.ready) begin
          out_v_nxt     = 1'b1;
          out_color_nxt = (ent_r.op == OP_READ) ? rext[CLR_W-1:0] : '0;
          out_cnt_nxt   = cnt_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ent_r       <= ent_nxt;
    row_base_r  <= row_base_nxt;
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    cnt_r       <= cnt_nxt;
    out_color_r <= out_color_nxt;
    out_cnt_r   <= out_cnt_nxt;
  end

  // frame store, one access a cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      frame[addr] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= frame[addr];
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.read_color     = out_color_r;
  assign out_ch.pixels_written = out_cnt_r;

  // checks
  a_run_in_span: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |-> (x_r < ent_r.x1 && y_r < ent_r.y1))
    else $error("pixel walk left the clipped span");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(state_r == ST_DONE))
    else $error("result loaded outside the done state");

  a_read_writes_none: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_cnt_r != '0) |-> out_color_r == '0)
    else $error("a command both wrote pixels and returned a colour");

  a_addr_in_store: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN || state_r == ST_READ) |-> int'(addr) < DEPTH)
    else $error("frame store address beyond the store");

endmodule

// ----- hdl/clipped_rectangle_fill.sv -----
// clipped_rectangle_fill: top level of the framebuffer fill engine
// depends on crf_pkg, crf_if, crf_front, crf_queue and crf_back
//
//   channel  direction  handshake            payload
//   in_ch    in         valid/ready          cmd, x_left, y_top, x_right, y_bottom, fill_color
//   out_ch   out        valid/ready          read_color, pixels_written
//   cfg_*    in         apb write, pready=1  canvas_width, canvas_height, base_color
//
// a fill or clear takes the back through setup, run and done; run writes the span pixel by pixel,
// bounded by the single write port of the frame store. a read goes through setup, read and done,
// and an empty, off-canvas or unused command skips to done. the front stage registers each word ahead
// of the queue, and the done state loads the result into the output register.
// the front takes one command a cycle into a two-entry queue while the back works, until the queue is full.
// reset is synchronous and active low; the frame store is not cleared and holds
// unknown data until a clear or fill writes it, so no pass runs after reset.
// a result waits in the output register while the back starts on the next command.
module clipped_rectangle_fill
  import crf_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int COLOR_BITS = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  crf_in_if.sink             in_ch,
  crf_out_if.source          out_ch,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [PADDR_W-1:0] cfg_paddr,
  input  logic [PDATA_W-1:0] cfg_pwdata,
  output logic [PDATA_W-1:0] cfg_prdata,
  output logic               cfg_pready
);

  logic [CRD_W-1:0] width_r, width_nxt, height_r, height_nxt;
  logic [CLR_W-1:0] base_r, base_nxt;
  logic [CRD_W-1:0] eff_w, eff_h;
  logic [1:0]       reg_idx;
  logic             cfg_wr;
  logic             push_valid, push_ready, q_valid, q_ready;
  crf_entry_t       push_entry, q_entry;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // register writes
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    base_nxt   = base_r;
    if (cfg_wr) begin
      case (reg_idx)
        REG_WIDTH:  width_nxt  = cfg_pwdata[CRD_W-1:0];
        REG_HEIGHT: height_nxt = cfg_pwdata[CRD_W-1:0];
        REG_BASE:   base_nxt   = cfg_pwdata[CLR_W-1:0];
        default:    width_nxt  = width_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CRD_W'(256);
      height_r <= CRD_W'(256);
      base_r   <= '0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      base_r   <= base_nxt;
    end
  end

  // register readback
  always_comb begin
    case (reg_idx)
      REG_WIDTH:  cfg_prdata = {{(PDATA_W-CRD_W){1'b0}}, width_r};
      REG_HEIGHT: cfg_prdata = {{(PDATA_W-CRD_W){1'b0}}, height_r};
      REG_BASE:   cfg_prdata = {{(PDATA_W-CLR_W){1'b0}}, base_r};
      default:    cfg_prdata = '0;
    endcase
  end

  // canvas size saturated to the store geometry
  assign eff_w = (int'(width_r) > MAX_WIDTH) ? CRD_W'(MAX_WIDTH) : width_r;
  assign eff_h = (int'(height_r) > MAX_HEIGHT) ? CRD_W'(MAX_HEIGHT) : height_r;

  crf_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .eff_w       (eff_w),
    .eff_h       (eff_h),
    .clear_color (base_r),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_entry  (push_entry)
  );

  crf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_entry (push_entry),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_entry (q_entry)
  );

  crf_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .COLOR_BITS (COLOR_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_entry (q_entry),
    .eff_w   (eff_w),
    .out_ch  (out_ch)
  );

endmodule

// ----- dv/clipped_rectangle_fill_test.sv -----
// clipped_rectangle_fill_test: self-checking testbench of the rectangle fill engine
// drives command words and apb register writes; each result word is predicted by a pixel model or given by the row
// depends on crf_pkg, crf_if and the clipped_rectangle_fill rtl
module clipped_rectangle_fill_test;
  timeunit 1ns;
  timeprecision 1ps;

  import crf_pkg::*;

  localparam int MAX_SIDE       = 256;
  localparam int STORE_WORDS    = MAX_SIDE * MAX_SIDE;
  localparam int HOLD_CYCLES    = 400;
  localparam int PHASE_WORDS    = 11;
  localparam int TIMEOUT_CYCLES = 1_500_000;

  // code outside the command list, and register index outside the register list
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [1:0] REG_SPARE  = 2'd3;

  typedef struct {
    logic [1:0]         cmd;
    logic signed [15:0] x_left;
    logic signed [15:0] y_top;
    logic signed [15:0] x_right;
    logic signed [15:0] y_bottom;
    logic [3:0]         fill_color;
  } fill_cmd_t;

  typedef struct {
    logic [3:0]  read_color;
    logic [16:0] pixels_written;
  } fill_result_t;

  typedef struct {
    fill_cmd_t    word;
    bit           typed;
    fill_result_t want;
  } stim_row_t;

  typedef struct {
    int width;
    int height;
    int base;
    int send_pct;
    int recv_pct;
    bit squeeze;
    bit spare_write;
  } phase_t;

  logic clk = 1'b0;
  logic rst_n;

  logic               cfg_psel;
  logic               cfg_penable;
  logic               cfg_pwrite;
  logic [PADDR_W-1:0] cfg_paddr;
  logic [PDATA_W-1:0] cfg_pwdata;
  logic [PDATA_W-1:0] cfg_prdata;
  logic               cfg_pready;

  crf_in_if  in_ch();
  crf_out_if out_ch();

  // own copy of the registers and of the frame store
  logic [8:0] cfg_width;
  logic [8:0] cfg_height;
  logic [3:0] cfg_base;
  logic [3:0] pixel_mem [0:STORE_WORDS-1];

  fill_result_t pending_results[$];
  stim_row_t    directed_rows[$];
  int           err_count = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  logic         squeeze_on = 1'b0;
  bit           squeeze_done = 1'b0;

  clipped_rectangle_fill dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #6 clk = ~clk;

  // canvas size in use, oversized registers saturate
  function automatic int eff_width();
    return (cfg_width > MAX_SIDE) ? MAX_SIDE : int'(cfg_width);
  endfunction

  function automatic int eff_height();
    return (cfg_height > MAX_SIDE) ? MAX_SIDE : int'(cfg_height);
  endfunction

  // pixel model: paints the clipped span or reads one pixel
  function automatic fill_result_t predict_pixels(fill_cmd_t word);
    fill_result_t res;
    int           w;
    int           h;
    int           x0;
    int           y0;
    int           x1;
    int           y1;
    int           px;
    int           py;
    logic [3:0]   paint_color;
    bit           do_paint;
    res.read_color     = '0;
    res.pixels_written = '0;
    w        = eff_width();
    h        = eff_height();
    do_paint = 1'b0;
    case (word.cmd)
      CMD_FILL: begin
        x0          = (word.x_left < 0) ? 0 : int'(word.x_left);
        y0          = (word.y_top < 0) ? 0 : int'(word.y_top);
        x1          = (word.x_right > w) ? w : int'(word.x_right);
        y1          = (word.y_bottom > h) ? h : int'(word.y_bottom);
        paint_color = word.fill_color;
        do_paint    = 1'b1;
      end
      CMD_CLEAR: begin
        x0          = 0;
        y0          = 0;
        x1          = w;
        y1          = h;
        paint_color = cfg_base;
        do_paint    = 1'b1;
      end
      CMD_READ: begin
        px = word.x_left;
        py = word.y_top;
        if (px >= 0 && px < w && py >= 0 && py < h) begin
          res.read_color = pixel_mem[py * w + px];
        end
      end
      default: ;
    endcase
    if (do_paint && x0 < x1 && y0 < y1) begin
      for (int y = y0; y < y1; y++) begin
        for (int x = x0; x < x1; x++) begin
          pixel_mem[y * w + x] = paint_color;
        end
      end
      res.pixels_written = 17'((x1 - x0) * (y1 - y0));
    end
    return res;
  endfunction

  function automatic void add_row(logic [1:0] cmd, int xl, int yt, int xr, int yb, int clr,
                                  bit typed = 1'b0, int want_color = 0, int want_count = 0);
    stim_row_t row;
    row.word.cmd                = cmd;
    row.word.x_left             = 16'(xl);
    row.word.y_top              = 16'(yt);
    row.word.x_right            = 16'(xr);
    row.word.y_bottom           = 16'(yb);
    row.word.fill_color         = 4'(clr);
    row.typed                   = typed;
    row.want.read_color         = 4'(want_color);
    row.want.pixels_written     = 17'(want_count);
    directed_rows.push_back(row);
  endfunction

  // random command word: mostly near the canvas, now and then anywhere
  function automatic fill_cmd_t random_word();
    fill_cmd_t word;
    int        pick;
    int        w;
    int        h;
    int        xl;
    int        yt;
    pick = $urandom_range(99);
    w    = eff_width();
    h    = eff_height();
    if (pick < 45) word.cmd = CMD_FILL;
    else if (pick < 55) word.cmd = CMD_CLEAR;
    else if (pick < 93) word.cmd = CMD_READ;
    else word.cmd = CMD_UNUSED;
    word.fill_color = 4'($urandom());
    if ($urandom_range(7) == 0) begin
      word.x_left   = 16'($urandom());
      word.y_top    = 16'($urandom());
      word.x_right  = 16'($urandom());
      word.y_bottom = 16'($urandom());
    end else begin
      xl            = int'($urandom_range(w + 8, 0)) - 4;
      yt            = int'($urandom_range(h + 8, 0)) - 4;
      word.x_left   = 16'(xl);
      word.y_top    = 16'(yt);
      word.x_right  = 16'(xl + int'($urandom_range(12, 0)) - 2);
      word.y_bottom = 16'(yt + int'($urandom_range(12, 0)) - 2);
    end
    return word;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    err_count++;
    $display("mismatch on %s at %0t: got %0d, expected %0d", what, $time, got, want);
  endtask

  // offer one command word, with random gaps before it, and book its result
  task automatic send_word(input fill_cmd_t word, input bit typed, input fill_result_t want);
    fill_result_t model_res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= word.cmd;
    in_ch.x_left     <= word.x_left;
    in_ch.y_top      <= word.y_top;
    in_ch.x_right    <= word.x_right;
    in_ch.y_bottom   <= word.y_bottom;
    in_ch.fill_color <= word.fill_color;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    model_res = predict_pixels(word);
    pending_results.push_back(typed ? want : model_res);
  endtask

  // apb write: setup cycle, access cycle, then back to idle
  task automatic cfg_write(input logic [1:0] idx, input logic [PDATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      REG_WIDTH:  cfg_width  = data[8:0];
      REG_HEIGHT: cfg_height = data[8:0];
      REG_BASE:   cfg_base   = data[3:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // result side: compare each accepted word with the oldest expectation
  always @(posedge clk) begin : result_check
    fill_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result word with none pending", out_ch.pixels_written, -1);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.read_color !== want.read_color)
          report_mismatch("read_color", out_ch.read_color, want.read_color);
        if (out_ch.pixels_written !== want.pixels_written)
          report_mismatch("pixels_written", out_ch.pixels_written, want.pixels_written);
      end
    end
  end

  // result side ready, with one long hold-off so the engine backs up
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze_on && !squeeze_done) begin
        squeeze_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // run limit
  initial begin
    repeat (TIMEOUT_CYCLES) @(posedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    phase_t       phases[7];
    fill_result_t no_want;
    no_want.read_color     = '0;
    no_want.pixels_written = '0;

    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.cmd        <= CMD_FILL;
    in_ch.x_left     <= '0;
    in_ch.y_top      <= '0;
    in_ch.x_right    <= '0;
    in_ch.y_bottom   <= '0;
    in_ch.fill_color <= '0;
    cfg_psel         <= 1'b0;
    cfg_penable      <= 1'b0;
    cfg_pwrite       <= 1'b0;
    cfg_paddr        <= '0;
    cfg_pwdata       <= '0;
    cfg_width  = 9'd256;
    cfg_height = 9'd256;
    cfg_base   = 4'd0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part on the reset canvas; the opening clear writes every entry,
    // so no later read can reach a pixel that was never written
    add_row(CMD_CLEAR, 0, 0, 0, 0, 0, 1, 0, 65536);
    add_row(CMD_READ, 0, 0, 0, 0, 0, 1, 0, 0);
    add_row(CMD_READ, 255, 255, 0, 0, 0, 1, 0, 0);
    add_row(CMD_FILL, -32768, -32768, 32767, 32767, 15, 1, 0, 65536);
    add_row(CMD_READ, 128, 7, 0, 0, 0, 1, 15, 0);
    // empty, reversed and off-canvas rectangles write nothing
    add_row(CMD_FILL, 10, 10, 10, 20, 3, 1, 0, 0);
    add_row(CMD_FILL, 32767, 32767, -32768, -32768, 3, 1, 0, 0);
    add_row(CMD_FILL, 256, 0, 300, 10, 3, 1, 0, 0);
    add_row(CMD_FILL, -5, -5, 0, 40, 3, 1, 0, 0);
    add_row(CMD_FILL, 0, 256, 10, 32767, 3, 1, 0, 0);
    add_row(CMD_FILL, 3, 4, 7, 6, 9);
    add_row(CMD_READ, 3, 4, 0, 0, 0);
    add_row(CMD_READ, 7, 4, 0, 0, 0);
    add_row(CMD_READ, 6, 5, 0, 0, 0);
    // reads outside the canvas
    add_row(CMD_READ, -1, 0, 0, 0, 0, 1, 0, 0);
    add_row(CMD_READ, 256, 0, 0, 0, 0, 1, 0, 0);
    add_row(CMD_READ, 0, 256, 0, 0, 0, 1, 0, 0);
    add_row(CMD_READ, 32767, -32768, 0, 0, 0, 1, 0, 0);
    // unused command code does nothing
    add_row(CMD_UNUSED, 1, 2, 200, 200, 12, 1, 0, 0);
    add_row(CMD_FILL, 255, 255, 256, 256, 5, 1, 0, 1);
    add_row(CMD_READ, 255, 255, 0, 0, 0, 1, 5, 0);
    add_row(CMD_FILL, -4, 10, 300, 11, 6);
    add_row(CMD_READ, 0, 10, 0, 0, 0);

    send_idle_pct = 37;
    recv_idle_pct = 61;
    foreach (directed_rows[i])
      send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);
    in_ch.valid <= 1'b0;

    // random phases: width, height, base, sender idle, receiver idle, hold-off, spare write
    phases[0] = '{16, 12, 10, 37, 61, 1'b0, 1'b0};
    phases[1] = '{1, 1, 0, 37, 61, 1'b0, 1'b1};
    phases[2] = '{511, 2, 15, 61, 37, 1'b0, 1'b0};
    phases[3] = '{5, 300, 6, 61, 37, 1'b0, 1'b0};
    phases[4] = '{0, 7, 3, 61, 37, 1'b0, 1'b0};
    phases[5] = '{256, 3, 7, 0, 0, 1'b0, 1'b0};
    phases[6] = '{9, 6, 12, 0, 0, 1'b1, 1'b0};

    foreach (phases[p]) begin
      wait_drained();
      cfg_write(REG_WIDTH, ($urandom() & ~32'h1FF) | PDATA_W'(phases[p].width));
      cfg_write(REG_HEIGHT, ($urandom() & ~32'h1FF) | PDATA_W'(phases[p].height));
      cfg_write(REG_BASE, ($urandom() & ~32'hF) | PDATA_W'(phases[p].base));
      if (phases[p].spare_write) cfg_write(REG_SPARE, $urandom());
      send_idle_pct = phases[p].send_pct;
      recv_idle_pct = phases[p].recv_pct;
      if (phases[p].squeeze) squeeze_on <= 1'b1;
      repeat (PHASE_WORDS) send_word(random_word(), 1'b0, no_want);
      in_ch.valid <= 1'b0;
    end

    // drain, then give stray words a chance to show
    wait_drained();
    repeat (16) @(posedge clk);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/crf_pkg.sv
hdl/crf_if.sv
hdl/crf_front.sv
hdl/crf_queue.sv
hdl/crf_back.sv
hdl/clipped_rectangle_fill.sv
dv/clipped_rectangle_fill_test.sv
